>>> hdl/rmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_pkg
// shared widths, defaults and the command code for the sorted cell chains
// ----------------------------------------------------------------------------
package rmh_pkg;

  localparam int HEAP_DEPTH_DEF = 512;
  localparam int VALUE_W        = 32;
  localparam int MED_W          = 33;
  localparam int TOTAL_W        = 10;
  localparam int OUT_DATA_W     = 48;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP
  } chain_cmd_t;

endpackage

>>> hdl/rmh_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_cell
// one slot of a sorted chain: holds one value, shifts on insert or pop
// ----------------------------------------------------------------------------
module rmh_cell #(
  parameter bit IS_MAX = 1'b1,
  parameter int INDEX  = 0,
  parameter int SW     = 10
) (
  input  logic                               clk,
  input  rmh_pkg::chain_cmd_t                cmd,
  input  logic signed [rmh_pkg::VALUE_W-1:0] ins_data,
  input  logic [SW-1:0]                      count,
  input  logic                               left_go,
  input  logic signed [rmh_pkg::VALUE_W-1:0] left_x,
  input  logic signed [rmh_pkg::VALUE_W-1:0] right_x,
  output logic                               go,
  output logic signed [rmh_pkg::VALUE_W-1:0] x
);
  import rmh_pkg::*;

  localparam logic [SW-1:0] IDX = SW'(INDEX);

  logic signed [VALUE_W-1:0] x_r;
  logic signed [VALUE_W-1:0] x_nxt;
  logic                      valid;
  logic                      ahead;

  assign valid = count > IDX;
  assign ahead = IS_MAX ? (ins_data > x_r) : (ins_data < x_r);
  assign go    = !valid || ahead;
  assign x     = x_r;

  always_comb begin
    x_nxt = x_r;
    case (cmd)
      CMD_INSERT: begin
        if (go) begin
          x_nxt = left_go ? left_x : ins_data;
        end
      end
      CMD_POP: x_nxt = right_x;
      default: x_nxt = x_r;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

endmodule

>>> hdl/rmh_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_chain
// row of cells kept in sorted order, best value at cell zero
// ----------------------------------------------------------------------------
module rmh_chain #(
  parameter bit IS_MAX     = 1'b1,
  parameter int HEAP_DEPTH = rmh_pkg::HEAP_DEPTH_DEF,
  parameter int SW         = $clog2(HEAP_DEPTH + 1)
) (
  input  logic                               clk,
  input  rmh_pkg::chain_cmd_t                cmd,
  input  logic signed [rmh_pkg::VALUE_W-1:0] ins_data,
  input  logic [SW-1:0]                      count,
  output logic signed [rmh_pkg::VALUE_W-1:0] top
);
  import rmh_pkg::*;

  logic signed [VALUE_W-1:0] x   [HEAP_DEPTH];
  logic                      go  [HEAP_DEPTH];

  genvar i;
  generate
    for (i = 0; i < HEAP_DEPTH; i++) begin : g_cell
      logic                      l_go;
      logic signed [VALUE_W-1:0] l_x;
      logic signed [VALUE_W-1:0] r_x;
      if (i == 0) begin : g_head
        assign l_go = 1'b0;
        assign l_x  = '0;
      end else begin : g_body
        assign l_go = go[i-1];
        assign l_x  = x[i-1];
      end
      if (i == HEAP_DEPTH - 1) begin : g_tail
        assign r_x = '0;
      end else begin : g_next
        assign r_x = x[i+1];
      end
      rmh_cell #(
        .IS_MAX (IS_MAX),
        .INDEX  (i),
        .SW     (SW)
      ) u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .ins_data (ins_data),
        .count    (count),
        .left_go  (l_go),
        .left_x   (l_x),
        .right_x  (r_x),
        .go       (go[i]),
        .x        (x[i])
      );
    end
  endgenerate

  assign top = x[0];

endmodule

>>> hdl/running_median_two_heaps_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit
// running median of a signed 32-bit stream, reported as twice the median
// ----------------------------------------------------------------------------
// The lower half of the data sits in a chain of HEAP_DEPTH cells sorted
// largest first and the upper half in a second chain sorted smallest first;
// each cell compares the broadcast value with its own and shifts by one, so
// a whole chain inserts or pops at once. An item passes through accept,
// insert, rebalance (pop from one chain into the other) and loading the
// output register; a dropped item skips the rebalance. The input is not
// ready again until that register has been loaded. Capacity is 2*HEAP_DEPTH-1
// values, after which items are dropped and flagged on out_tuser.
module running_median_two_heaps_unit #(
  parameter int HEAP_DEPTH = rmh_pkg::HEAP_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rmh_pkg::VALUE_W-1:0]       in_tdata,   // [31:0] value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rmh_pkg::OUT_DATA_W-1:0]    out_tdata,  // [32:0] median_doubled,
                                                        // [42:33] element_total
  output logic                              out_tuser   // [0] rejected
);
  import rmh_pkg::*;

  localparam int SW  = $clog2(HEAP_DEPTH + 1);
  localparam int CW  = $clog2(2 * HEAP_DEPTH);
  localparam int TW  = (CW > TOTAL_W) ? CW : TOTAL_W;
  localparam logic [TW-1:0] CAPACITY = TW'(2 * HEAP_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_BAL,
    S_OUT
  } state_t;

  state_t                    state_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [SW-1:0]             lower_size_r;
  logic [SW-1:0]             upper_size_r;
  logic                      rej_r;
  logic                      out_tvalid_r;
  logic [MED_W-1:0]          out_med_r;
  logic [TOTAL_W-1:0]        out_total_r;
  logic                      out_rej_r;

  chain_cmd_t                lower_cmd;
  chain_cmd_t                upper_cmd;
  logic signed [VALUE_W-1:0] lower_ins;
  logic signed [VALUE_W-1:0] upper_ins;
  logic signed [VALUE_W-1:0] lower_top;
  logic signed [VALUE_W-1:0] upper_top;

  logic [TW-1:0]             total;
  logic                      full;
  logic                      go_lower;
  logic                      lower_big;
  logic                      upper_big;
  logic [MED_W-1:0]          median;
  logic signed [VALUE_W-1:0] odd_top;

  assign total     = TW'(lower_size_r) + TW'(upper_size_r);
  assign full      = total >= CAPACITY;
  assign go_lower  = (lower_size_r != '0) && (lower_top > value_r);
  assign lower_big = {1'b0, lower_size_r} > ({1'b0, upper_size_r} + (SW+1)'(1));
  assign upper_big = {1'b0, upper_size_r} > ({1'b0, lower_size_r} + (SW+1)'(1));

  always_comb begin
    lower_cmd = CMD_HOLD;
    upper_cmd = CMD_HOLD;
    lower_ins = value_r;
    upper_ins = value_r;
    unique case (state_r)
      S_INS: begin
        if (!full) begin
          if (go_lower) begin
            lower_cmd = CMD_INSERT;
          end else begin
            upper_cmd = CMD_INSERT;
          end
        end
      end
      S_BAL: begin
        if (lower_big) begin
          lower_cmd = CMD_POP;
          upper_cmd = CMD_INSERT;
          upper_ins = lower_top;
        end else if (upper_big) begin
          upper_cmd = CMD_POP;
          lower_cmd = CMD_INSERT;
          lower_ins = upper_top;
        end
      end
      default: begin
        lower_cmd = CMD_HOLD;
        upper_cmd = CMD_HOLD;
      end
    endcase
  end

  rmh_chain #(
    .IS_MAX     (1'b1),
    .HEAP_DEPTH (HEAP_DEPTH),
    .SW         (SW)
  ) u_lower (
    .clk      (clk),
    .cmd      (lower_cmd),
    .ins_data (lower_ins),
    .count    (lower_size_r),
    .top      (lower_top)
  );

  rmh_chain #(
    .IS_MAX     (1'b0),
    .HEAP_DEPTH (HEAP_DEPTH),
    .SW         (SW)
  ) u_upper (
    .clk      (clk),
    .cmd      (upper_cmd),
    .ins_data (upper_ins),
    .count    (upper_size_r),
    .top      (upper_top)
  );

  // odd count: larger chain's top doubled, even count: sum of both tops
  assign odd_top = (lower_size_r > upper_size_r) ? lower_top : upper_top;

  always_comb begin
    if (total[0]) begin
      median = {odd_top, 1'b0};
    end else if ((lower_size_r != '0) && (upper_size_r != '0)) begin
      median = {lower_top[VALUE_W-1], lower_top} + {upper_top[VALUE_W-1], upper_top};
    end else begin
      median = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lower_size_r <= '0;
      upper_size_r <= '0;
      rej_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            value_r <= in_tdata;
            state_r <= S_INS;
          end
        end
        S_INS: begin
          rej_r <= full;
          if (full) begin
            state_r <= S_OUT;
          end else begin
            if (go_lower) begin
              lower_size_r <= lower_size_r + SW'(1);
            end else begin
              upper_size_r <= upper_size_r + SW'(1);
            end
            state_r <= S_BAL;
          end
        end
        S_BAL: begin
          if (lower_big) begin
            lower_size_r <= lower_size_r - SW'(1);
            upper_size_r <= upper_size_r + SW'(1);
          end else if (upper_big) begin
            upper_size_r <= upper_size_r - SW'(1);
            lower_size_r <= lower_size_r + SW'(1);
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_med_r    <= median;
            out_total_r  <= total[TOTAL_W-1:0];
            out_rej_r    <= rej_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - MED_W - TOTAL_W){1'b0}}, out_total_r, out_med_r};
  assign out_tuser  = out_rej_r;

endmodule

>>> hdl/rmh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_checker
// port-level checks on the running median unit, bound to the top level
// ----------------------------------------------------------------------------
module rmh_checker #(
  parameter int HEAP_DEPTH = rmh_pkg::HEAP_DEPTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [rmh_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);
  import rmh_pkg::*;

  localparam logic [TOTAL_W-1:0] CAP_SEEN = TOTAL_W'(2 * HEAP_DEPTH - 1);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready straight after a transaction");

  // dropped value only when full
  a_rej_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[MED_W +: TOTAL_W] == CAP_SEEN)
    else $error("rejection below capacity");

  // odd count reports a doubled top, so no half bit
  a_odd_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[MED_W] |-> !out_tdata[0])
    else $error("half bit set with odd count");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind running_median_two_heaps_unit rmh_checker #(
  .HEAP_DEPTH (HEAP_DEPTH)
) u_rmh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
